### rtl/signal_window_mean_max_macros.svh
// Assertion macros for the top-level RTL file of the window mean and peak block.
`ifndef SIGNAL_WINDOW_MEAN_MAX_MACROS_SVH
`define SIGNAL_WINDOW_MEAN_MAX_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SWMM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swmm assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SWMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swmm assertion failed");

`endif

### rtl/swmm_pkg.sv
package swmm_pkg;

  localparam int DEFAULT_WINDOW_DEPTH = 16;
  localparam int SAMPLE_W             = 16;
  localparam int PEAK_W               = 15;
  localparam int COUNT_W              = 5;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DIVS,
    ST_DIV,
    ST_FINISH
  } state_e;

  // accumulator control
  typedef struct packed {
    logic clr;
    logic en;
  } acc_ctrl_t;

endpackage

### rtl/swmm_ring.sv
module swmm_ring import swmm_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [IDX_W-1:0]           wr_addr_i,
  input  logic signed [SAMPLE_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [IDX_W-1:0]           rd_addr_i,
  output logic signed [SAMPLE_W-1:0] rd_data_o
);

  logic signed [SAMPLE_W-1:0] mem [WINDOW_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_q;

  // write one sample
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/swmm_accum.sv
module swmm_accum import swmm_pkg::*; #(
  parameter int SUM_W = 21
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  acc_ctrl_t                  ctrl_i,
  input  logic signed [SAMPLE_W-1:0] data_i,
  output logic signed [SUM_W-1:0]    sum_o,
  output logic [PEAK_W-1:0]          peak_o
);

  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] peak_q, peak_d;

  // add and compare one ring entry
  always_comb begin
    sum_d  = sum_q;
    peak_d = peak_q;
    if (ctrl_i.clr) begin
      sum_d  = '0;
      peak_d = '0;
    end else if (ctrl_i.en) begin
      sum_d = sum_q + SUM_W'(data_i);
      if (data_i > peak_q) begin
        peak_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      peak_q <= '0;
    end else begin
      sum_q  <= sum_d;
      peak_q <= peak_d;
    end
  end

  assign sum_o  = sum_q;
  // peak starts at zero, so the sign bit is always clear
  assign peak_o = peak_q[PEAK_W-1:0];

endmodule

### rtl/swmm_div.sv
module swmm_div import swmm_pkg::*; #(
  parameter int SUM_W = 21,
  parameter int CNT_W = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SUM_W-1:0]    sum_i,
  input  logic [CNT_W-1:0]           count_i,
  output logic                       done_o,
  output logic signed [SAMPLE_W-1:0] mean_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q, rem_d, dvs_q;
  logic [SUM_W-1:0]  dq_q, mag, res;
  logic              neg_q, qbit;
  logic [CNT_W:0]    trial;

  assign mag = sum_i[SUM_W-1] ? (~sum_i + SUM_W'(1)) : sum_i;

  // one restoring step: shift in a dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dq_q[SUM_W-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
  end

  // sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= mag;
      neg_q <= sum_i[SUM_W-1];
      dvs_q <= count_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= {dq_q[SUM_W-2:0], qbit};
    end
  end

  // restore the sign: truncation toward zero
  assign res    = neg_q ? (~dq_q + SUM_W'(1)) : dq_q;
  assign mean_o = res[SAMPLE_W-1:0];
  assign done_o = done_q;

endmodule

### rtl/signal_window_mean_max.sv
// Sliding-window mean and peak of a signed Q8.8 signal-to-noise stream. Each
// accepted item is written into a ring of WINDOW_DEPTH samples, then the held
// samples are walked one per cycle through a single adder/comparator and the
// sum is divided by the fill count one quotient bit per cycle. Each item gives
// one result; the peak is floored at zero and sample_count saturates at the
// depth (masked to five bits). The result waits until the output register is
// free, and the next item can be taken in the cycle after the result is
// loaded. in_ready_o is high only between items.
`include "signal_window_mean_max_macros.svh"

module signal_window_mean_max import swmm_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] signal_db_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] average_db_o,
  output logic [PEAK_W-1:0]          peak_db_o,
  output logic [COUNT_W-1:0]         sample_count_o
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  wpos_q, wpos_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              rd_vld_q;
  logic              accept, last_idx, rd_en, div_start, div_done, load_out;
  acc_ctrl_t         acc_ctrl;

  logic signed [SAMPLE_W-1:0] rd_data, mean;
  logic signed [SUM_W-1:0]    sum;
  logic [PEAK_W-1:0]          peak;
  logic [31:0]                fill_ext;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] average_q;
  logic [PEAK_W-1:0]          peak_q;
  logic [COUNT_W-1:0]         count_q;

  assign accept   = in_valid_i && in_ready_o;
  assign last_idx = (idx_q == fill_q - CNT_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_WALK;
      ST_WALK:   if (last_idx) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_DIVS;
      ST_DIVS:   state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    rd_en        = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    acc_ctrl.clr = 1'b0;
    acc_ctrl.en  = rd_vld_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        acc_ctrl.clr = in_valid_i;
      end
      ST_WALK:   rd_en = 1'b1;
      ST_DIVS:   div_start = 1'b1;
      ST_FINISH: load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // advance write position, fill count and walk index
  always_comb begin
    wpos_d = wpos_q;
    fill_d = fill_q;
    idx_d  = idx_q;
    if (accept) begin
      wpos_d = (wpos_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + IDX_W'(1);
      if (fill_q < CNT_W'(WINDOW_DEPTH)) begin
        fill_d = fill_q + CNT_W'(1);
      end
      idx_d = '0;
    end else if (rd_en) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wpos_q   <= '0;
      fill_q   <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wpos_q   <= wpos_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_en;
    end
  end

  swmm_ring #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (wpos_q),
    .wr_data_i (signal_db_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  swmm_accum #(
    .SUM_W(SUM_W)
  ) u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .data_i (rd_data),
    .sum_o  (sum),
    .peak_o (peak)
  );

  swmm_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum),
    .count_i (fill_q),
    .done_o  (div_done),
    .mean_o  (mean)
  );

  // hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign fill_ext = 32'(fill_q);

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      average_q <= mean;
      peak_q    <= peak;
      count_q   <= fill_ext[COUNT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign average_db_o   = average_q;
  assign peak_db_o      = peak_q;
  assign sample_count_o = count_q;

  `SWMM_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CNT_W'(WINDOW_DEPTH))
  `SWMM_ASSERT_IMPL(a_done_in_div, div_done, state_q == ST_DIV)
  `SWMM_ASSERT_NEXT(a_accept_walk, accept, state_q == ST_WALK && fill_q != '0)
  `SWMM_ASSERT_IMPL(a_walk_bound, state_q == ST_WALK, idx_q < fill_q)

endmodule
